/* design/xoshiro256ss_generator_macros.svh */
`ifndef XOSHIRO256SS_GENERATOR_MACROS_SVH
`define XOSHIRO256SS_GENERATOR_MACROS_SVH

// Assertion helpers. Both sample on aclk and are held off while aresetn is low.

`ifndef SYNTHESIS

`define XSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define XSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XSS_ASSERT_IMP(lbl, ante, cons, msg)

`define XSS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* design/xss_pkg.sv */
package xss_pkg;

    localparam int WORD_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 2;
    localparam int NUM_WORDS = 4;
    localparam int MAX_BYTES = 8;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [WORD_W-1:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL2  = 64'h94d049bb133111eb;

    typedef enum logic [1:0] {
        CMD_RESEED     = 2'd0,
        CMD_LOAD       = 2'd1,
        CMD_NEXT_WORD  = 2'd2,
        CMD_NEXT_BYTES = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_SCRAMBLE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [INDEX_W-1:0]   word_index;
        logic [WORD_W-1:0]    word_value;
        logic [COUNT_W-1:0]   count;
    } queue_entry_t;

endpackage

/* design/xoshiro256ss_generator.sv */
// A small queue takes a command in the cycle it is offered while space remains.
// Load writes its state word when the back end takes it from the queue; next word advances the state,
// scrambles the word and holds it on the output until the output is ready, next bytes presents one byte
// per accepted output transfer, and an all-zero state instead presents a single error word with status set.
// Reseed runs nine phases per state word on the shared 32 by 32 multiplier.
// Synchronous active-low reset clears the queue, the seed register and all four state words to zero.
module xoshiro256ss_generator #(
    parameter int QUEUE_DEPTH = xss_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [xss_pkg::WORD_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [xss_pkg::INDEX_W-1:0]   s_word_index,
    input  logic [xss_pkg::WORD_W-1:0]    s_word_value,
    input  logic [xss_pkg::COUNT_W-1:0]   s_byte_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [xss_pkg::WORD_W-1:0]    m_random_word,
    output logic [xss_pkg::BYTE_W-1:0]    m_random_byte,
    output logic                          m_last,
    output logic                          m_status
);

    logic                  q_valid;
    logic                  q_ready;
    xss_pkg::queue_entry_t q_entry;

    xss_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_word_index (s_word_index),
        .s_word_value (s_word_value),
        .s_byte_count (s_byte_count),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_entry      (q_entry)
    );

    xss_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_entry       (q_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word),
        .m_random_byte (m_random_byte),
        .m_last        (m_last),
        .m_status      (m_status)
    );

endmodule

/* design/xss_front.sv */
module xss_front #(
    parameter int QUEUE_DEPTH = xss_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [xss_pkg::INDEX_W-1:0]   s_word_index,
    input  logic [xss_pkg::WORD_W-1:0]    s_word_value,
    input  logic [xss_pkg::COUNT_W-1:0]   s_byte_count,
    output logic                          q_valid,
    input  logic                          q_ready,
    output xss_pkg::queue_entry_t         q_entry
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    xss_pkg::queue_entry_t entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    xss_pkg::queue_entry_t cls;
    logic drop;
    logic push;
    logic pop;

    // Decode the word and saturate the byte count; a bytes request for zero bytes is dropped.
    always_comb begin
        cls.word_index = s_word_index;
        cls.word_value = s_word_value;
        cls.count      = s_byte_count;
        drop           = 1'b0;
        case (s_command)
            xss_pkg::CMD_RESEED: begin
                cls.cmd = xss_pkg::CMD_RESEED;
            end
            xss_pkg::CMD_LOAD: begin
                cls.cmd = xss_pkg::CMD_LOAD;
            end
            xss_pkg::CMD_NEXT_WORD: begin
                cls.cmd = xss_pkg::CMD_NEXT_WORD;
            end
            default: begin
                cls.cmd = xss_pkg::CMD_NEXT_BYTES;
                if (s_byte_count == '0) begin
                    drop = 1'b1;
                end
                if (s_byte_count > xss_pkg::COUNT_W'(xss_pkg::MAX_BYTES)) begin
                    cls.count = xss_pkg::COUNT_W'(xss_pkg::MAX_BYTES);
                end
            end
        endcase
    end

    assign s_ready = (fill_reg != FILL_FULL);
    assign push    = s_valid && s_ready && !drop;
    assign q_valid = (fill_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* design/xss_back.sv */
`include "xoshiro256ss_generator_macros.svh"

module xss_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [xss_pkg::WORD_W-1:0]    cfg_wr_data,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  xss_pkg::queue_entry_t         q_entry,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [xss_pkg::WORD_W-1:0]    m_random_word,
    output logic [xss_pkg::BYTE_W-1:0]    m_random_byte,
    output logic                          m_last,
    output logic                          m_status
);

    localparam int W = xss_pkg::WORD_W;
    localparam int H = W / 2;

    // Seeding sequence, one word per nine phases.
    localparam logic [3:0] PH_ADD     = 4'd0;
    localparam logic [3:0] PH_M1_HI   = 4'd2;
    localparam logic [3:0] PH_M1_CROSS = 4'd3;
    localparam logic [3:0] PH_M1_LAST = 4'd4;
    localparam logic [3:0] PH_M2_HI   = 4'd6;
    localparam logic [3:0] PH_M2_CROSS = 4'd7;
    localparam logic [3:0] PH_M2_LAST = 4'd8;

    xss_pkg::back_state_t bk_state_reg, bk_state_next;

    logic [W-1:0] gen_reg [xss_pkg::NUM_WORDS];
    logic [W-1:0] gen_next [xss_pkg::NUM_WORDS];
    logic [W-1:0] seed_reg;

    logic [3:0]   phase_reg, phase_next;
    logic [1:0]   word_cnt_reg, word_cnt_next;
    logic [W-1:0] ctr_reg, ctr_next;
    logic [W-1:0] z_reg, z_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] prod_reg, prod_next;
    logic [W-1:0] r5_reg, r5_next;
    logic         bytes_op_reg, bytes_op_next;
    logic [xss_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [xss_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [W-1:0] shift_reg, shift_next;

    logic         m_valid_reg, m_valid_next;
    logic [W-1:0] m_word_reg, m_word_next;
    logic [xss_pkg::BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic         m_last_reg, m_last_next;
    logic         m_status_reg, m_status_next;

    logic [W-1:0] mul_const;
    logic [H-1:0] mul_a;
    logic [H-1:0] mul_b;
    logic [W-1:0] mix_sum;
    logic [W-1:0] ctr_add;
    logic [W-1:0] rot_r5;
    logic [W-1:0] scrambled;
    logic [W-1:0] n3;
    logic         state_zero;

    assign q_ready       = (bk_state_reg == xss_pkg::BK_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;
    assign m_random_byte = m_byte_reg;
    assign m_last        = m_last_reg;
    assign m_status      = m_status_reg;

    // One 32 by 32 partial product per phase; the three products give the low 64 bits.
    assign mul_const = (phase_reg <= PH_M1_LAST) ? xss_pkg::MIX_MUL1 : xss_pkg::MIX_MUL2;
    assign mul_a = (phase_reg == PH_M1_HI || phase_reg == PH_M2_HI) ? z_reg[W-1:H] : z_reg[H-1:0];
    assign mul_b = (phase_reg == PH_M1_CROSS || phase_reg == PH_M2_CROSS) ?
                   mul_const[W-1:H] : mul_const[H-1:0];
    assign mix_sum = acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
    assign ctr_add = ctr_reg + xss_pkg::MIX_GAMMA;

    assign rot_r5    = {r5_reg[W-8:0], r5_reg[W-1:W-7]};
    assign scrambled = rot_r5 + {rot_r5[W-4:0], 3'b000};

    assign state_zero = ((gen_reg[0] | gen_reg[1] | gen_reg[2] | gen_reg[3]) == '0);
    assign n3 = gen_reg[3] ^ gen_reg[1];

    always_comb begin
        bk_state_next = bk_state_reg;
        for (int i = 0; i < xss_pkg::NUM_WORDS; i++) begin
            gen_next[i] = gen_reg[i];
        end
        phase_next    = phase_reg;
        word_cnt_next = word_cnt_reg;
        ctr_next      = ctr_reg;
        z_next        = z_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        r5_next       = r5_reg;
        bytes_op_next = bytes_op_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        shift_next    = shift_reg;
        m_valid_next  = m_valid_reg;
        m_word_next   = m_word_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        case (bk_state_reg)
            xss_pkg::BK_IDLE: begin
                if (q_valid) begin
                    case (q_entry.cmd)
                        xss_pkg::CMD_RESEED: begin
                            ctr_next      = seed_reg;
                            phase_next    = PH_ADD;
                            word_cnt_next = '0;
                            bk_state_next = xss_pkg::BK_MIX;
                        end
                        xss_pkg::CMD_LOAD: begin
                            gen_next[q_entry.word_index] = q_entry.word_value;
                        end
                        default: begin
                            bytes_op_next = (q_entry.cmd == xss_pkg::CMD_NEXT_BYTES);
                            count_next    = q_entry.count;
                            if (state_zero) begin
                                m_valid_next  = 1'b1;
                                m_word_next   = '0;
                                m_byte_next   = '0;
                                m_last_next   = 1'b1;
                                m_status_next = 1'b1;
                                rem_next      = xss_pkg::COUNT_W'(1);
                                bk_state_next = xss_pkg::BK_EMIT;
                            end else begin
                                r5_next     = gen_reg[1] + {gen_reg[1][W-3:0], 2'b00};
                                gen_next[2] = gen_reg[2] ^ gen_reg[0]
                                              ^ {gen_reg[1][W-18:0], 17'd0};
                                gen_next[1] = gen_reg[1] ^ gen_reg[2] ^ gen_reg[0];
                                gen_next[0] = gen_reg[0] ^ n3;
                                gen_next[3] = {n3[W-46:0], n3[W-1:W-45]};
                                bk_state_next = xss_pkg::BK_SCRAMBLE;
                            end
                        end
                    endcase
                end
            end
            xss_pkg::BK_MIX: begin
                prod_next  = W'(mul_a) * W'(mul_b);
                phase_next = phase_reg + 4'd1;
                if (phase_reg == PH_ADD) begin
                    ctr_next = ctr_add;
                    z_next   = ctr_add ^ (ctr_add >> 30);
                end else if (phase_reg == PH_M1_HI || phase_reg == PH_M2_HI) begin
                    acc_next = prod_reg;
                end else if (phase_reg == PH_M1_CROSS || phase_reg == PH_M2_CROSS) begin
                    acc_next = mix_sum;
                end else if (phase_reg == PH_M1_LAST) begin
                    z_next = mix_sum ^ (mix_sum >> 27);
                end else if (phase_reg == PH_M2_LAST) begin
                    gen_next[word_cnt_reg] = mix_sum ^ (mix_sum >> 31);
                    phase_next    = PH_ADD;
                    word_cnt_next = word_cnt_reg + 2'd1;
                    if (word_cnt_reg == 2'd3) begin
                        bk_state_next = xss_pkg::BK_IDLE;
                    end
                end
            end
            xss_pkg::BK_SCRAMBLE: begin
                m_valid_next  = 1'b1;
                m_word_next   = scrambled;
                m_status_next = 1'b0;
                shift_next    = scrambled;
                if (bytes_op_reg) begin
                    m_byte_next = scrambled[W-1:W-8];
                    rem_next    = count_reg;
                    m_last_next = (count_reg == xss_pkg::COUNT_W'(1));
                end else begin
                    m_byte_next = '0;
                    rem_next    = xss_pkg::COUNT_W'(1);
                    m_last_next = 1'b1;
                end
                bk_state_next = xss_pkg::BK_EMIT;
            end
            xss_pkg::BK_EMIT: begin
                if (m_ready) begin
                    if (m_last_reg) begin
                        m_valid_next  = 1'b0;
                        bk_state_next = xss_pkg::BK_IDLE;
                    end else begin
                        m_byte_next = shift_reg[W-9:W-16];
                        shift_next  = {shift_reg[W-9:0], 8'd0};
                        rem_next    = rem_reg - xss_pkg::COUNT_W'(1);
                        m_last_next = (rem_reg == xss_pkg::COUNT_W'(2));
                    end
                end
            end
            default: begin
                bk_state_next = xss_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bk_state_reg <= xss_pkg::BK_IDLE;
            m_valid_reg  <= 1'b0;
            seed_reg     <= '0;
            for (int i = 0; i < xss_pkg::NUM_WORDS; i++) begin
                gen_reg[i] <= '0;
            end
        end else begin
            bk_state_reg <= bk_state_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            for (int i = 0; i < xss_pkg::NUM_WORDS; i++) begin
                gen_reg[i] <= gen_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        word_cnt_reg <= word_cnt_next;
        ctr_reg      <= ctr_next;
        z_reg        <= z_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        r5_reg       <= r5_next;
        bytes_op_reg <= bytes_op_next;
        count_reg    <= count_next;
        rem_reg      <= rem_next;
        shift_reg    <= shift_next;
        m_word_reg   <= m_word_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    `XSS_ASSERT_IMP(a_valid_only_emit, m_valid_reg, bk_state_reg == xss_pkg::BK_EMIT,
                    "output word outside emit")
    `XSS_ASSERT_IMP(a_error_single, m_valid_reg && m_status_reg,
                    m_last_reg && m_word_reg == '0, "error word malformed")
    `XSS_ASSERT_NXT(a_mix_done,
                    bk_state_reg == xss_pkg::BK_MIX && phase_reg == PH_M2_LAST
                        && word_cnt_reg == 2'd3,
                    bk_state_reg == xss_pkg::BK_IDLE, "reseed did not finish")
    `XSS_ASSERT_NXT(a_emit_follows, bk_state_reg == xss_pkg::BK_SCRAMBLE,
                    m_valid_reg && !m_status_reg, "scrambled word not presented")

endmodule

/* bench/xoshiro256ss_generator_tb.sv */
`timescale 1ns / 100ps

module xoshiro256ss_generator_tb;

    localparam int WORD_W    = xss_pkg::WORD_W;
    localparam int BYTE_W    = xss_pkg::BYTE_W;
    localparam int INDEX_W   = xss_pkg::INDEX_W;
    localparam int COUNT_W   = xss_pkg::COUNT_W;
    localparam int NUM_WORDS = xss_pkg::NUM_WORDS;
    localparam int MAX_BYTES = xss_pkg::MAX_BYTES;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 42;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [BYTE_W-1:0] out_byte;
        logic              last_flag;
        logic              status_flag;
    } gen_result_t;

    typedef struct packed {
        xss_pkg::cmd_t      cmd;
        logic [INDEX_W-1:0] word_idx;
        logic [WORD_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               typed;
        gen_result_t        known;
    } cmd_row_t;

    localparam gen_result_t NO_RESULT      = '0;
    localparam gen_result_t ZERO_STATE_ERR = '{64'h0, 8'h00, 1'b1, 1'b1};

    localparam int NUM_ROWS = 24;
    localparam cmd_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{xss_pkg::CMD_NEXT_WORD,  2'd0, 64'h0,                4'd0,  1'b1, ZERO_STATE_ERR},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd3, 64'hffffffffffffffff, 4'd3,  1'b1, ZERO_STATE_ERR},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd1, 64'h0,                4'd15, 1'b1, ZERO_STATE_ERR},
        '{xss_pkg::CMD_RESEED,     2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_WORD,  2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd1,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd8,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd15, 1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd9,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd0, 64'hffffffffffffffff, 4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd1, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd2, 64'hffffffffffffffff, 4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd3, 64'h8000000000000001, 4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_WORD,  2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd1, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd2, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_LOAD,       2'd3, 64'h0,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_WORD,  2'd2, 64'h5555555555555555, 4'd7,  1'b1, ZERO_STATE_ERR},
        '{xss_pkg::CMD_LOAD,       2'd1, 64'h1,                4'd0,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_BYTES, 2'd0, 64'h0,                4'd8,  1'b0, NO_RESULT},
        '{xss_pkg::CMD_NEXT_WORD,  2'd0, 64'h0,                4'd0,  1'b0, NO_RESULT}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [WORD_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_command;
    logic [INDEX_W-1:0]   s_word_index;
    logic [WORD_W-1:0]    s_word_value;
    logic [COUNT_W-1:0]   s_byte_count;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_W-1:0]    m_random_word;
    logic [BYTE_W-1:0]    m_random_byte;
    logic                 m_last;
    logic                 m_status;

    logic [WORD_W-1:0]    seed_reg;
    logic [WORD_W-1:0]    gen_state [NUM_WORDS];
    gen_result_t          expected_q [$];

    int mismatches     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int zero_errors    = 0;
    int reseeds        = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    int stall_mode     = 0;
    int stall_span     = 0;

    xoshiro256ss_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_word_index  (s_word_index),
        .s_word_value  (s_word_value),
        .s_byte_count  (s_byte_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word),
        .m_random_byte (m_random_byte),
        .m_last        (m_last),
        .m_status      (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_results(input cmd_row_t it);
        logic [WORD_W-1:0] ctr;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] t;
        gen_result_t       res;
        int                n;
        case (it.cmd)
            xss_pkg::CMD_RESEED: begin
                ctr = seed_reg;
                for (int i = 0; i < NUM_WORDS; i++) begin
                    ctr = ctr + xss_pkg::MIX_GAMMA;
                    z = ctr;
                    z = (z ^ (z >> 30)) * xss_pkg::MIX_MUL1;
                    z = (z ^ (z >> 27)) * xss_pkg::MIX_MUL2;
                    gen_state[i] = z ^ (z >> 31);
                end
                reseeds++;
            end
            xss_pkg::CMD_LOAD: begin
                gen_state[it.word_idx] = it.value;
            end
            default: begin
                if (it.cmd == xss_pkg::CMD_NEXT_WORD) begin
                    n = 1;
                end else begin
                    n = (it.count > COUNT_W'(MAX_BYTES)) ? MAX_BYTES : int'(it.count);
                end
                if (n != 0) begin
                    if ((gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]) == '0) begin
                        expected_q.push_back(ZERO_STATE_ERR);
                        zero_errors++;
                    end else begin
                        z = gen_state[1] * 64'd5;
                        w = {z[56:0], z[63:57]} * 64'd9;
                        t = gen_state[1] << 17;
                        gen_state[2] = gen_state[2] ^ gen_state[0];
                        gen_state[3] = gen_state[3] ^ gen_state[1];
                        gen_state[1] = gen_state[1] ^ gen_state[2];
                        gen_state[0] = gen_state[0] ^ gen_state[3];
                        gen_state[2] = gen_state[2] ^ t;
                        gen_state[3] = {gen_state[3][18:0], gen_state[3][63:19]};
                        res.out_word    = w;
                        res.status_flag = 1'b0;
                        if (it.cmd == xss_pkg::CMD_NEXT_WORD) begin
                            res.out_byte  = 8'h00;
                            res.last_flag = 1'b1;
                            expected_q.push_back(res);
                        end else begin
                            for (int i = 0; i < n; i++) begin
                                res.out_byte  = w[63 - 8 * i -: 8];
                                res.last_flag = (i == n - 1);
                                expected_q.push_back(res);
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic send_cmd(input cmd_row_t it);
        int gap;
        int before_len;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        end
        s_valid      <= 1'b1;
        s_command    <= it.cmd;
        s_word_index <= it.word_idx;
        s_word_value <= it.value;
        s_byte_count <= it.count;
        do @(posedge aclk); while (!(s_valid && s_ready));
        before_len = expected_q.size();
        predict_results(it);
        if (it.typed) begin
            while (expected_q.size() > before_len) void'(expected_q.pop_back());
            expected_q.push_back(it.known);
        end
        words_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic settle_and_write_seed(input logic [WORD_W-1:0] seed);
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        seed_reg = seed;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_random_phase(input int count);
        cmd_row_t it;
        int       sent;
        int       pick;
        sent = 0;
        it = '0;
        it.cmd = xss_pkg::CMD_RESEED;
        send_cmd(it);
        while (sent < count) begin
            it.typed    = 1'b0;
            it.known    = NO_RESULT;
            it.word_idx = INDEX_W'($urandom_range(0, 3));
            it.value    = {$urandom, $urandom};
            it.count    = COUNT_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                it.cmd = xss_pkg::CMD_RESEED;
            end else if (pick < 9) begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    it.cmd      = xss_pkg::CMD_LOAD;
                    it.word_idx = INDEX_W'(i);
                    it.value    = '0;
                    send_cmd(it);
                end
                it.cmd = xss_pkg::CMD_NEXT_WORD;
            end else if (pick < 25) begin
                it.cmd   = xss_pkg::CMD_LOAD;
                it.value = random_value();
            end else if (pick < 62) begin
                it.cmd = xss_pkg::CMD_NEXT_BYTES;
                if ($urandom_range(0, 9) < 7) it.count = COUNT_W'($urandom_range(1, 8));
            end else begin
                it.cmd = xss_pkg::CMD_NEXT_WORD;
            end
            send_cmd(it);
            sent++;
        end
    endtask

    always @(negedge aclk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 80);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        gen_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                flag_mismatch("unexpected word", m_random_word, '0);
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (m_random_word !== want.out_word)
                    flag_mismatch("random_word", m_random_word, want.out_word);
                if (m_random_byte !== want.out_byte)
                    flag_mismatch("random_byte", WORD_W'(m_random_byte), WORD_W'(want.out_byte));
                if (m_last !== want.last_flag)
                    flag_mismatch("last", WORD_W'(m_last), WORD_W'(want.last_flag));
                if (m_status !== want.status_flag)
                    flag_mismatch("status", WORD_W'(m_status), WORD_W'(want.status_flag));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_command    = xss_pkg::CMD_RESEED;
        s_word_index = '0;
        s_word_value = '0;
        s_byte_count = '0;
        seed_reg     = '0;
        for (int i = 0; i < NUM_WORDS; i++) gen_state[i] = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < NUM_ROWS; r++) send_cmd(DIRECTED_ROWS[r]);

        settle_and_write_seed(64'h7fffffffffffffff);
        run_random_phase(PHASE_WORDS);
        settle_and_write_seed(64'h8000000000000000);
        run_random_phase(PHASE_WORDS);
        settle_and_write_seed(64'hffffffffffffffff);
        run_random_phase(PHASE_WORDS);
        settle_and_write_seed({$urandom, $urandom});
        run_random_phase(PHASE_WORDS);
        settle_and_write_seed(64'h0);
        run_random_phase(PHASE_WORDS);
        settle_and_write_seed({$urandom, $urandom});
        run_random_phase(PHASE_WORDS);

        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d command words under seven seed settings, including %0d reseeds.",
                 words_sent, reseeds);
        $display("Checked %0d result words, %0d of them zero-state errors; %0d mismatches.",
                 results_seen, zero_errors, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
